[rtl/ecmb_pkg.sv]
// Shared constants, types and arithmetic helpers of the camera matrix builder.
package ecmb_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int CORDIC_STEPS    = 16;
  localparam int CORDIC_Q        = 30;

  localparam int AW = 16;        // angle width
  localparam int PW = 32;        // position width
  localparam int EW = 32;        // matrix entry width
  localparam int CW = 34;        // CORDIC x/y width, Q30 with headroom
  localparam int ZW = 26;        // CORDIC residual angle width, degrees Q16
  localparam int MW = 2 * EW;    // product width
  localparam int SW = MW + 2;    // width of a sum of three products

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
  localparam logic signed [EW-1:0] ONE         = EW'(1 << FRAC_BITS);
  localparam logic signed [EW-1:0] EMAX        = {1'b0, {(EW-1){1'b1}}};
  localparam logic signed [EW-1:0] EMIN        = {1'b1, {(EW-1){1'b0}}};
  localparam logic [1:0]           ROW_LAST    = 2'd3;

  typedef logic signed [EW-1:0] elem_t;
  typedef elem_t mat3_t [3][3];
  typedef elem_t vec3_t [3];

  typedef enum logic [2:0] {
    MODE_XYZ = 3'd0,
    MODE_YXZ = 3'd1,
    MODE_XZY = 3'd2,
    MODE_YZX = 3'd3,
    MODE_ZYX = 3'd4,
    MODE_ZXY = 3'd5
  } mode_t;

  // Payload that rides alongside the sine/cosine pipeline.
  typedef struct {
    vec3_t      t;
    logic [2:0] mode;
  } cam_side_t;

  // Payload that rides alongside a matrix product.
  typedef struct {
    mat3_t c;
    vec3_t t;
  } mm_side_t;

  // Arctangent of 2^-i in degrees, Q16.
  function automatic logic signed [ZW-1:0] atan_deg(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = ZW'(2949120);
      1:  v = ZW'(1740967);
      2:  v = ZW'(919879);
      3:  v = ZW'(466945);
      4:  v = ZW'(234379);
      5:  v = ZW'(117304);
      6:  v = ZW'(58666);
      7:  v = ZW'(29335);
      8:  v = ZW'(14668);
      9:  v = ZW'(7334);
      10: v = ZW'(3667);
      11: v = ZW'(1833);
      12: v = ZW'(917);
      13: v = ZW'(458);
      14: v = ZW'(229);
      15: v = ZW'(115);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round half up by FRAC_BITS and saturate to an entry.
  function automatic elem_t round_sat(input logic signed [SW-1:0] acc);
    logic signed [SW-1:0] r;
    r = (acc + SW'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (r > SW'(EMAX)) begin
      return EMAX;
    end else if (r < SW'(EMIN)) begin
      return EMIN;
    end
    return EW'(r);
  endfunction

endpackage

[rtl/ecmb_sincos.sv]
// Three-lane pipelined CORDIC that gives sine and cosine of angles in degrees.
module ecmb_sincos (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [ecmb_pkg::AW-1:0] ang [3],
  input  ecmb_pkg::cam_side_t           side_in,
  output logic                          out_valid,
  output ecmb_pkg::elem_t               sin_o [3],
  output ecmb_pkg::elem_t               cos_o [3],
  output ecmb_pkg::cam_side_t           side_out
);
  import ecmb_pkg::*;

  localparam int NST = CORDIC_STEPS + 2;
  localparam int ZSH = 16 - ANGLE_FRAC_BITS;
  localparam int RSH = CORDIC_Q - FRAC_BITS;
  localparam logic signed [AW:0] A_FULL = (AW+1)'(360 << ANGLE_FRAC_BITS);
  localparam logic signed [AW:0] A_HALF = (AW+1)'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [AW:0] A_QTR  = (AW+1)'(90 << ANGLE_FRAC_BITS);
  localparam logic signed [CW-1:0] CRND = CW'(1 << (RSH - 1));

  logic [NST-1:0]          vld;
  cam_side_t               sd [NST];
  logic signed [CW-1:0]    xs [CORDIC_STEPS+1][3];
  logic signed [CW-1:0]    ys [CORDIC_STEPS+1][3];
  logic signed [ZW-1:0]    zs [CORDIC_STEPS+1][3];
  logic                    ng [CORDIC_STEPS+1][3];
  logic signed [ZW-1:0]    zinit [3];
  logic                    neginit [3];

  // Reduce to [-180,180) and fold into [-90,90].
  always_comb begin
    logic signed [AW:0] r0;
    logic signed [AW:0] r1;
    logic signed [AW:0] m;
    for (int l = 0; l < 3; l++) begin
      r0 = {ang[l][AW-1], ang[l]};
      if (r0 >= A_HALF) begin
        r1 = r0 - A_FULL;
      end else if (r0 < -A_HALF) begin
        r1 = r0 + A_FULL;
      end else begin
        r1 = r0;
      end
      neginit[l] = 1'b1;
      if (r1 > A_QTR) begin
        m = A_HALF - r1;
      end else if (r1 < -A_QTR) begin
        m = -A_HALF - r1;
      end else begin
        m = r1;
        neginit[l] = 1'b0;
      end
      zinit[l] = ZW'(m) <<< ZSH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= side_in;
      for (int k = 1; k < NST; k++) sd[k] <= sd[k-1];
      for (int l = 0; l < 3; l++) begin
        xs[0][l] <= CORDIC_GAIN;
        ys[0][l] <= '0;
        zs[0][l] <= zinit[l];
        ng[0][l] <= neginit[l];
      end
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          if (zs[k][l] >= 0) begin
            xs[k+1][l] <= xs[k][l] - (ys[k][l] >>> k);
            ys[k+1][l] <= ys[k][l] + (xs[k][l] >>> k);
            zs[k+1][l] <= zs[k][l] - atan_deg(k);
          end else begin
            xs[k+1][l] <= xs[k][l] + (ys[k][l] >>> k);
            ys[k+1][l] <= ys[k][l] - (xs[k][l] >>> k);
            zs[k+1][l] <= zs[k][l] + atan_deg(k);
          end
          ng[k+1][l] <= ng[k][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [CW-1:0] yr;
    logic signed [CW-1:0] xr;
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        yr = (ys[CORDIC_STEPS][l] + CRND) >>> RSH;
        xr = (xs[CORDIC_STEPS][l] + CRND) >>> RSH;
        sin_o[l] <= EW'(yr);
        cos_o[l] <= ng[CORDIC_STEPS][l] ? -EW'(xr) : EW'(xr);
      end
    end
  end

  assign out_valid = vld[NST-1];
  assign side_out  = sd[NST-1];

endmodule

[rtl/ecmb_matmul.sv]
// Two-stage 3x3 fixed-point matrix product with rounding and saturation.
module ecmb_matmul (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  ecmb_pkg::mat3_t    a,
  input  ecmb_pkg::mat3_t    b,
  input  ecmb_pkg::mm_side_t side_in,
  output logic               out_valid,
  output ecmb_pkg::mat3_t    p,
  output ecmb_pkg::mm_side_t side_out
);
  import ecmb_pkg::*;

  logic [1:0]           vld;
  logic signed [MW-1:0] prod [3][3][3];
  mm_side_t             sd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd1      <= side_in;
      side_out <= sd1;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            prod[i][j][k] <= MW'(a[i][k]) * MW'(b[k][j]);
          end
          p[i][j] <= round_sat(SW'(prod[i][j][0]) + SW'(prod[i][j][1]) +
                               SW'(prod[i][j][2]));
        end
      end
    end
  end

  assign out_valid = vld[1];

endmodule

[rtl/ecmb_row3.sv]
// Two-stage product of the inverse translation row with the rotation.
module ecmb_row3 (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  ecmb_pkg::vec3_t t,
  input  ecmb_pkg::mat3_t rot,
  output logic            out_valid,
  output ecmb_pkg::vec3_t r3,
  output ecmb_pkg::mat3_t rot_out
);
  import ecmb_pkg::*;

  logic [1:0]           vld;
  logic signed [MW-1:0] prod [3][3];
  mat3_t                rot1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot1    <= rot;
      rot_out <= rot1;
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          prod[j][k] <= MW'(t[k]) * MW'(rot[k][j]);
        end
        r3[j] <= round_sat(SW'(prod[j][0]) + SW'(prod[j][1]) + SW'(prod[j][2]));
      end
    end
  end

  assign out_valid = vld[1];

endmodule

[rtl/euler_camera_matrix_builder_core.sv]
// Top level of the Euler-angle camera view matrix builder.
//
// Each input word carries a camera position (Q16.16) and three Euler angles in
// 1/64 degree, with the rotation order in tuser, and produces four output words,
// the rows of the 4x4 view matrix in row-vector convention, row 0 first and
// tlast on row 3. The work runs through a single pipeline: a three-lane 16-step
// CORDIC (18 register stages) for the sines and cosines, two 3x3 matrix
// products for the rotation order (two stages each) and the translation row
// product (two stages), 24 stages in all, followed by an output register that
// holds one matrix while its rows are sent. Once the pipeline is full, an input
// word is therefore taken only as the last row of the previous matrix leaves;
// the input rate is set by the output channel, which moves one row per word.
// The whole pipeline holds while its tail word waits for the busy output
// register, so nothing is lost or repeated under back-pressure. Rows 0 to 2
// carry the rotation with zero in column 3; row 3 carries the rotated, negated
// position and 1.0 in column 3. Unused order codes give the identity rotation.
module euler_camera_matrix_builder_core
  import ecmb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x [31:0], pos_y [63:32], pos_z [95:64], angle_x [111:96],
  // angle_y [127:112], angle_z [143:128]
  input  logic [143:0] s_tdata,
  // mode [2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // col0 [31:0], col1 [63:32], col2 [95:64], col3 [127:96]
  output logic [127:0] m_tdata,
  // row_index [1:0]
  output logic [1:0]   m_tuser,
  output logic         m_tlast
);

  // Pipeline advance: everything moves together unless the tail word is
  // waiting for the output register.
  logic en;
  logic load_out;

  logic signed [PW-1:0] pos [3];
  logic signed [AW-1:0] ang [3];
  cam_side_t            side0;

  logic      sc_valid;
  elem_t     sin_v [3];
  elem_t     cos_v [3];
  cam_side_t sc_side;

  mat3_t    rx, ry, rz, ri;
  mat3_t    ma, mb, mc;
  mm_side_t mm1_in;

  logic     mm1_valid, mm2_valid, r3_valid;
  mat3_t    p1, p2, rot_t;
  mm_side_t mm1_side, mm2_side;
  vec3_t    r3_t;

  logic       ovalid;
  logic [1:0] row;
  mat3_t      rot_q;
  vec3_t      r3_q;

  // Unpack the input word and form the negated position, saturating -2^31.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      pos[l] = s_tdata[l*PW +: PW];
      ang[l] = s_tdata[3*PW + l*AW +: AW];
      side0.t[l] = (pos[l] == EMIN) ? EMAX : -pos[l];
    end
    side0.mode = s_tuser;
  end

  assign s_tready = en;

  ecmb_sincos u_sincos (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .ang       (ang),
    .side_in   (side0),
    .out_valid (sc_valid),
    .sin_o     (sin_v),
    .cos_o     (cos_v),
    .side_out  (sc_side)
  );

  // Inverse rotations: the angle is negated, so the sine enters with its sign
  // flipped. The order code then picks the three factors.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ri[i][j] = (i == j) ? ONE : '0;
      end
    end
    rx = ri;
    ry = ri;
    rz = ri;
    rx[1][1] = cos_v[0]; rx[1][2] = -sin_v[0];
    rx[2][1] = sin_v[0]; rx[2][2] = cos_v[0];
    ry[0][0] = cos_v[1]; ry[0][2] = sin_v[1];
    ry[2][0] = -sin_v[1]; ry[2][2] = cos_v[1];
    rz[0][0] = cos_v[2]; rz[0][1] = -sin_v[2];
    rz[1][0] = sin_v[2]; rz[1][1] = cos_v[2];
    case (mode_t'(sc_side.mode))
      MODE_XYZ: begin ma = rx; mb = ry; mc = rz; end
      MODE_YXZ: begin ma = ry; mb = rx; mc = rz; end
      MODE_XZY: begin ma = rx; mb = rz; mc = ry; end
      MODE_YZX: begin ma = ry; mb = rz; mc = rx; end
      MODE_ZYX: begin ma = rz; mb = ry; mc = rx; end
      MODE_ZXY: begin ma = rz; mb = rx; mc = ry; end
      default:  begin ma = ri; mb = ri; mc = ri; end
    endcase
    mm1_in.c = mc;
    mm1_in.t = sc_side.t;
  end

  ecmb_matmul u_mm1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sc_valid),
    .a         (ma),
    .b         (mb),
    .side_in   (mm1_in),
    .out_valid (mm1_valid),
    .p         (p1),
    .side_out  (mm1_side)
  );

  ecmb_matmul u_mm2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (mm1_valid),
    .a         (p1),
    .b         (mm1_side.c),
    .side_in   (mm1_side),
    .out_valid (mm2_valid),
    .p         (p2),
    .side_out  (mm2_side)
  );

  ecmb_row3 u_row3 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (mm2_valid),
    .t         (mm2_side.t),
    .rot       (p2),
    .out_valid (r3_valid),
    .r3        (r3_t),
    .rot_out   (rot_t)
  );

  // The output register takes a new matrix when empty or when row 3 leaves.
  assign load_out = !ovalid || (m_tready && row == ROW_LAST);
  assign en       = !r3_valid || load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      row    <= '0;
    end else if (load_out) begin
      ovalid <= r3_valid;
      row    <= '0;
    end else if (m_tready) begin
      row <= row + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rot_q <= rot_t;
      r3_q  <= r3_t;
    end
  end

  always_comb begin
    if (row == ROW_LAST) begin
      m_tdata = {ONE, r3_q[2], r3_q[1], r3_q[0]};
    end else begin
      m_tdata = {{EW{1'b0}}, rot_q[row][2], rot_q[row][1], rot_q[row][0]};
    end
  end

  assign m_tvalid = ovalid;
  assign m_tuser  = row;
  assign m_tlast  = (row == ROW_LAST);

  // The pipeline only holds an input back while the output register is full.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && !s_tready) |-> m_tvalid)
    else $error("input held back with the output register empty");

  // Rows of one matrix follow each other in order without a gap.
  a_row_seq: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tvalid && m_tuser == $past(m_tuser) + 2'd1))
    else $error("matrix rows out of order or interrupted");

  // Column 3 of rows 0 to 2 is zero, and tlast marks row 3 only.
  a_col3: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[127:96] == '0 && m_tuser != ROW_LAST))
    else $error("non-zero column 3 on a rotation row");

endmodule
